@@ src/tdvq_pkg.sv @@
package tdvq_pkg;

   localparam int FuncWidth     = 2;
   localparam int CoordWidth    = 10;
   localparam int StepWidth     = 11;
   localparam int ValueWidth    = 24;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 24;

   localparam int MulAWidth   = 26;
   localparam int MulBWidth   = 12;
   localparam int ProdWidth   = MulAWidth + MulBWidth;
   localparam int AccWidth    = 23;
   localparam int DivNumWidth = 36;
   localparam int DivDenWidth = 26;
   localparam int DivSteps    = DivNumWidth / 2;
   localparam int DivCntWidth = $clog2(DivSteps + 1);

   localparam logic [CsrIndexWidth-1:0] CSR_CENTER_X    = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_CENTER_Y    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_DIAL_RADIUS = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_MIN_VALUE   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_VALUE   = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_STEP_COUNT  = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_START_VALUE = 3'd6;

   localparam logic [CoordWidth-1:0] RADIUS_RESET = 10'd32;
   localparam logic [ValueWidth-1:0] MAX_RESET    = 24'd25600;
   localparam logic [StepWidth-1:0]  STEPS_RESET  = 11'd1;

   typedef enum logic [FuncWidth-1:0] {
      FUNC_BEGIN = 2'd0,
      FUNC_MOVE  = 2'd1,
      FUNC_TAP   = 2'd2,
      FUNC_END   = 2'd3
   } tdvq_func_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_HIT_DX,
      OP_HIT_DY,
      OP_HIT_RR,
      OP_HIT_FIN,
      OP_DRAG_MUL,
      OP_DRAG_DIV,
      OP_DRAG_SUM,
      OP_COMMIT_PLAIN,
      OP_SNAP_MUL1,
      OP_SNAP_DIV1,
      OP_SNAP_IDX,
      OP_SNAP_MUL2,
      OP_SNAP_DIV2,
      OP_SNAP_FIN,
      OP_TAP,
      OP_EMIT
   } tdvq_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_HIT_DX,
      ST_HIT_DY,
      ST_HIT_RR,
      ST_HIT_FIN,
      ST_DRAG_MUL,
      ST_DRAG_DIV,
      ST_DRAG_WAIT,
      ST_DRAG_SUM,
      ST_SNAP_CHK,
      ST_SNAP_MUL1,
      ST_SNAP_DIV1,
      ST_SNAP_WAIT1,
      ST_SNAP_IDX,
      ST_SNAP_MUL2,
      ST_SNAP_DIV2,
      ST_SNAP_WAIT2,
      ST_SNAP_FIN,
      ST_TAP,
      ST_EMIT
   } tdvq_state_type;

   typedef struct packed {
      tdvq_func_type func;
      logic          div_done;
      logic          snap_on;
      logic          out_full;
   } tdvq_status_type;

endpackage

@@ src/tdvq_if.sv @@
interface tdvq_req_if;
   logic                             valid;
   logic                             ready;
   logic [tdvq_pkg::FuncWidth-1:0]   func;
   logic [tdvq_pkg::CoordWidth-1:0]  touch_x;
   logic [tdvq_pkg::CoordWidth-1:0]  touch_y;

   modport source (output valid, output func, output touch_x, output touch_y, input ready);
   modport sink   (input valid, input func, input touch_x, input touch_y, output ready);
endinterface

interface tdvq_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   hit;
   logic signed [tdvq_pkg::ValueWidth-1:0] dial_value;
   logic                                   tapped;

   modport source (output valid, output hit, output dial_value, output tapped, input ready);
   modport sink   (input valid, input hit, input dial_value, input tapped, output ready);
endinterface

interface tdvq_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [tdvq_pkg::CsrIndexWidth-1:0]   reg_index;
   logic [tdvq_pkg::CsrDataWidth-1:0]    wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ src/tdvq_div.sv @@
module tdvq_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [tdvq_pkg::DivNumWidth-1:0]   dividend,
   input  logic [tdvq_pkg::DivDenWidth-1:0]   divisor,
   output logic [tdvq_pkg::DivNumWidth-1:0]   quotient,
   output logic                               rem_nz,
   output logic                               done
);

   localparam int NW = tdvq_pkg::DivNumWidth;
   localparam int DW = tdvq_pkg::DivDenWidth;

   logic [NW-1:0]                      quo_ff, quo_in;
   logic [DW-1:0]                      rem_ff, rem_in;
   logic [DW-1:0]                      den_ff;
   logic [tdvq_pkg::DivCntWidth-1:0]   cnt_ff;
   logic                               busy_ff;
   logic                               done_ff;

   logic [DW:0] part1, part2;
   logic [DW-1:0] rem1;
   logic ge1, ge2;

   always_comb begin
      part1 = {rem_ff, quo_ff[NW-1]};
      ge1   = part1 >= {1'b0, den_ff};
      rem1  = ge1 ? DW'(part1 - {1'b0, den_ff}) : part1[DW-1:0];
      part2 = {rem1, quo_ff[NW-2]};
      ge2   = part2 >= {1'b0, den_ff};
      rem_in = ge2 ? DW'(part2 - {1'b0, den_ff}) : part2[DW-1:0];
      quo_in = {quo_ff[NW-3:0], ge1, ge2};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= tdvq_pkg::DivCntWidth'(tdvq_pkg::DivSteps);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == tdvq_pkg::DivCntWidth'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient = quo_ff;
   assign rem_nz   = rem_ff != '0;
   assign done     = done_ff;

endmodule

@@ src/tdvq_datapath.sv @@
module tdvq_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tdvq_pkg::tdvq_op_type                  op,
   output tdvq_pkg::tdvq_status_type              status,
   input  logic [tdvq_pkg::FuncWidth-1:0]         req_func,
   input  logic [tdvq_pkg::CoordWidth-1:0]        req_touch_x,
   input  logic [tdvq_pkg::CoordWidth-1:0]        req_touch_y,
   input  logic                                   csr_valid,
   input  logic [tdvq_pkg::CsrIndexWidth-1:0]     csr_reg_index,
   input  logic [tdvq_pkg::CsrDataWidth-1:0]      csr_wr_data,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic                                   rsp_hit,
   output logic signed [tdvq_pkg::ValueWidth-1:0] rsp_dial_value,
   output logic                                   rsp_tapped
);

   localparam int CW = tdvq_pkg::CoordWidth;
   localparam int VW = tdvq_pkg::ValueWidth;
   localparam int SW = tdvq_pkg::StepWidth;
   localparam int PW = tdvq_pkg::ProdWidth;
   localparam int AW = tdvq_pkg::AccWidth;
   localparam int NW = tdvq_pkg::DivNumWidth;
   localparam int DW = tdvq_pkg::DivDenWidth;

   logic [CW-1:0]        cx_ff, cy_ff, rad_ff;
   logic signed [VW-1:0] min_ff, max_ff;
   logic [SW-1:0]        steps_ff;
   logic signed [VW-1:0] cur_ff, grab_ff;
   logic [CW-1:0]        grab_y_ff;
   logic                 tap_ff;

   logic [tdvq_pkg::FuncWidth-1:0] func_ff;
   logic [CW-1:0]        x_ff, y_ff;
   logic                 hit_ff;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [AW-1:0]        acc_ff;
   logic                 neg_ff;
   logic signed [VW-1:0] v_ff, v_in;
   logic [SW-1:0]        idx_ff, idx_in;

   logic                 rsp_valid_ff, rsp_hit_ff, rsp_tapped_ff;
   logic signed [VW-1:0] rsp_value_ff;

   logic signed [VW:0]   range_w;
   logic                 range_pos, snap_on;
   logic [SW-1:0]        levels_w;
   logic signed [CW:0]   dx_w, dy_w, travel_w;
   logic [CW-1:0]        r_eff_w;
   logic [VW:0]          voff_w;

   logic signed [tdvq_pkg::MulAWidth-1:0] mul_a;
   logic signed [tdvq_pkg::MulBWidth-1:0] mul_b;
   logic                 mul_en;

   logic signed [PW-1:0] n_drag;
   logic [PW-1:0]        n_drag_mag;
   logic [NW-1:0]        div_num, div_quo;
   logic [DW-1:0]        div_den;
   logic                 div_start, div_rem_nz, div_done;

   logic signed [PW-1:0] delta_w, vsum_w, min_ext, max_ext;
   logic [PW-1:0]        qmag_w;
   logic                 hit_test;
   logic signed [VW-1:0] snap_val, plain_val;

   assign range_w   = {max_ff[VW-1], max_ff} - {min_ff[VW-1], min_ff};
   assign range_pos = ~range_w[VW] & (range_w != '0);
   assign levels_w  = steps_ff - SW'(1);
   assign snap_on   = (steps_ff > SW'(1)) & range_pos;
   assign dx_w      = {1'b0, x_ff} - {1'b0, cx_ff};
   assign dy_w      = {1'b0, y_ff} - {1'b0, cy_ff};
   assign travel_w  = {1'b0, grab_y_ff} - {1'b0, y_ff};
   assign r_eff_w   = (rad_ff == '0) ? CW'(1) : rad_ff;
   assign voff_w    = {v_ff[VW-1], v_ff} - {min_ff[VW-1], min_ff};

   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      unique case (op)
         tdvq_pkg::OP_HIT_DX: begin
            mul_a = {{(tdvq_pkg::MulAWidth-CW-1){dx_w[CW]}}, dx_w};
            mul_b = {{(tdvq_pkg::MulBWidth-CW-1){dx_w[CW]}}, dx_w};
         end
         tdvq_pkg::OP_HIT_DY: begin
            mul_a = {{(tdvq_pkg::MulAWidth-CW-1){dy_w[CW]}}, dy_w};
            mul_b = {{(tdvq_pkg::MulBWidth-CW-1){dy_w[CW]}}, dy_w};
         end
         tdvq_pkg::OP_HIT_RR: begin
            mul_a = {{(tdvq_pkg::MulAWidth-CW){1'b0}}, rad_ff};
            mul_b = {{(tdvq_pkg::MulBWidth-CW){1'b0}}, rad_ff};
         end
         tdvq_pkg::OP_DRAG_MUL: begin
            mul_a = {range_w[VW], range_w};
            mul_b = {{(tdvq_pkg::MulBWidth-CW-1){travel_w[CW]}}, travel_w};
         end
         tdvq_pkg::OP_SNAP_MUL1: begin
            mul_a = {1'b0, voff_w};
            mul_b = {1'b0, levels_w};
         end
         tdvq_pkg::OP_SNAP_MUL2: begin
            mul_a = {range_w[VW], range_w};
            mul_b = {1'b0, idx_ff};
         end
         default: mul_en = 1'b0;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   assign n_drag     = {prod_ff[PW-2:0], 1'b0} + {{(PW-CW-1){1'b0}}, r_eff_w, 1'b0};
   assign n_drag_mag = n_drag[PW-1] ? (~n_drag + PW'(1)) : n_drag;

   always_comb begin
      div_num   = '0;
      div_den   = '0;
      div_start = 1'b1;
      unique case (op)
         tdvq_pkg::OP_DRAG_DIV: begin
            div_num = n_drag_mag[NW-1:0];
            div_den = {{(DW-CW-2){1'b0}}, r_eff_w, 2'b00};
         end
         tdvq_pkg::OP_SNAP_DIV1: begin
            div_num = {prod_ff[NW-2:0], 1'b0} + {{(NW-VW){1'b0}}, range_w[VW-1:0]};
            div_den = {range_w, 1'b0};
         end
         tdvq_pkg::OP_SNAP_DIV2: begin
            div_num = {prod_ff[NW-2:0], 1'b0} + {{(NW-SW){1'b0}}, levels_w};
            div_den = {{(DW-SW-1){1'b0}}, levels_w, 1'b0};
         end
         default: div_start = 1'b0;
      endcase
   end

   tdvq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .quotient (div_quo),
      .rem_nz   (div_rem_nz),
      .done     (div_done)
   );

   // floor division of a signed numerator from the magnitude quotient, added to the grab value and clamped to min/max
   always_comb begin
      qmag_w = {{(PW-NW){1'b0}}, div_quo};
      if (!range_pos) begin
         delta_w = '0;
      end else if (neg_ff) begin
         delta_w = -(qmag_w + {{(PW-1){1'b0}}, div_rem_nz});
      end else begin
         delta_w = qmag_w;
      end
      vsum_w  = {{(PW-VW){grab_ff[VW-1]}}, grab_ff} + delta_w;
      min_ext = {{(PW-VW){min_ff[VW-1]}}, min_ff};
      max_ext = {{(PW-VW){max_ff[VW-1]}}, max_ff};
      if (vsum_w < min_ext) begin
         v_in = min_ff;
      end else if (vsum_w > max_ext) begin
         v_in = max_ff;
      end else begin
         v_in = vsum_w[VW-1:0];
      end
   end

   assign idx_in    = (div_quo > {{(NW-SW){1'b0}}, levels_w}) ? levels_w : div_quo[SW-1:0];
   assign snap_val  = min_ff + div_quo[VW-1:0];
   assign plain_val = (steps_ff <= SW'(1)) ? v_ff : min_ff;
   assign hit_test  = acc_ff <= prod_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff        <= '0;
         cy_ff        <= '0;
         rad_ff       <= tdvq_pkg::RADIUS_RESET;
         min_ff       <= '0;
         max_ff       <= tdvq_pkg::MAX_RESET;
         steps_ff     <= tdvq_pkg::STEPS_RESET;
         cur_ff       <= '0;
         grab_ff      <= '0;
         grab_y_ff    <= '0;
         tap_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (op)
            tdvq_pkg::OP_HIT_FIN: begin
               if (hit_test) begin
                  grab_ff   <= cur_ff;
                  grab_y_ff <= y_ff;
               end
            end
            tdvq_pkg::OP_COMMIT_PLAIN: cur_ff <= plain_val;
            tdvq_pkg::OP_SNAP_FIN:     cur_ff <= snap_val;
            tdvq_pkg::OP_TAP:          tap_ff <= 1'b1;
            default: ;
         endcase
         if (op == tdvq_pkg::OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            unique case (csr_reg_index)
               tdvq_pkg::CSR_CENTER_X:    cx_ff    <= csr_wr_data[CW-1:0];
               tdvq_pkg::CSR_CENTER_Y:    cy_ff    <= csr_wr_data[CW-1:0];
               tdvq_pkg::CSR_DIAL_RADIUS: rad_ff   <= csr_wr_data[CW-1:0];
               tdvq_pkg::CSR_MIN_VALUE:   min_ff   <= csr_wr_data[VW-1:0];
               tdvq_pkg::CSR_MAX_VALUE:   max_ff   <= csr_wr_data[VW-1:0];
               tdvq_pkg::CSR_STEP_COUNT:  steps_ff <= csr_wr_data[SW-1:0];
               tdvq_pkg::CSR_START_VALUE: cur_ff   <= csr_wr_data[VW-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      case (op)
         tdvq_pkg::OP_LOAD: begin
            func_ff <= req_func;
            x_ff    <= req_touch_x;
            y_ff    <= req_touch_y;
            hit_ff  <= 1'b0;
         end
         tdvq_pkg::OP_HIT_DY:   acc_ff <= prod_ff[AW-1:0];
         tdvq_pkg::OP_HIT_RR:   acc_ff <= acc_ff + prod_ff[AW-1:0];
         tdvq_pkg::OP_HIT_FIN:  hit_ff <= hit_test;
         tdvq_pkg::OP_DRAG_DIV: neg_ff <= n_drag[PW-1];
         tdvq_pkg::OP_DRAG_SUM: v_ff   <= v_in;
         tdvq_pkg::OP_SNAP_IDX: idx_ff <= idx_in;
         tdvq_pkg::OP_EMIT: begin
            rsp_hit_ff    <= hit_ff;
            rsp_value_ff  <= cur_ff;
            rsp_tapped_ff <= tap_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      status.func     = tdvq_pkg::tdvq_func_type'(func_ff);
      status.div_done = div_done;
      status.snap_on  = snap_on;
      status.out_full = rsp_valid_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_dial_value = rsp_value_ff;
   assign rsp_tapped     = rsp_tapped_ff;

endmodule

@@ src/tdvq_ctrl.sv @@
module tdvq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  tdvq_pkg::tdvq_status_type status,
   output tdvq_pkg::tdvq_op_type     op,
   output logic                      req_ready
);

   tdvq_pkg::tdvq_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdvq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tdvq_pkg::ST_IDLE: begin
            if (req_valid) state_in = tdvq_pkg::ST_DISPATCH;
         end
         tdvq_pkg::ST_DISPATCH: begin
            unique case (status.func)
               tdvq_pkg::FUNC_BEGIN: state_in = tdvq_pkg::ST_HIT_DX;
               tdvq_pkg::FUNC_MOVE:  state_in = tdvq_pkg::ST_DRAG_MUL;
               tdvq_pkg::FUNC_TAP:   state_in = tdvq_pkg::ST_TAP;
               tdvq_pkg::FUNC_END:   state_in = tdvq_pkg::ST_EMIT;
               default:              state_in = tdvq_pkg::ST_EMIT;
            endcase
         end
         tdvq_pkg::ST_HIT_DX:    state_in = tdvq_pkg::ST_HIT_DY;
         tdvq_pkg::ST_HIT_DY:    state_in = tdvq_pkg::ST_HIT_RR;
         tdvq_pkg::ST_HIT_RR:    state_in = tdvq_pkg::ST_HIT_FIN;
         tdvq_pkg::ST_HIT_FIN:   state_in = tdvq_pkg::ST_EMIT;
         tdvq_pkg::ST_DRAG_MUL:  state_in = tdvq_pkg::ST_DRAG_DIV;
         tdvq_pkg::ST_DRAG_DIV:  state_in = tdvq_pkg::ST_DRAG_WAIT;
         tdvq_pkg::ST_DRAG_WAIT: begin
            if (status.div_done) state_in = tdvq_pkg::ST_DRAG_SUM;
         end
         tdvq_pkg::ST_DRAG_SUM:  state_in = tdvq_pkg::ST_SNAP_CHK;
         tdvq_pkg::ST_SNAP_CHK: begin
            state_in = status.snap_on ? tdvq_pkg::ST_SNAP_MUL1 : tdvq_pkg::ST_EMIT;
         end
         tdvq_pkg::ST_SNAP_MUL1:  state_in = tdvq_pkg::ST_SNAP_DIV1;
         tdvq_pkg::ST_SNAP_DIV1:  state_in = tdvq_pkg::ST_SNAP_WAIT1;
         tdvq_pkg::ST_SNAP_WAIT1: begin
            if (status.div_done) state_in = tdvq_pkg::ST_SNAP_IDX;
         end
         tdvq_pkg::ST_SNAP_IDX:   state_in = tdvq_pkg::ST_SNAP_MUL2;
         tdvq_pkg::ST_SNAP_MUL2:  state_in = tdvq_pkg::ST_SNAP_DIV2;
         tdvq_pkg::ST_SNAP_DIV2:  state_in = tdvq_pkg::ST_SNAP_WAIT2;
         tdvq_pkg::ST_SNAP_WAIT2: begin
            if (status.div_done) state_in = tdvq_pkg::ST_SNAP_FIN;
         end
         tdvq_pkg::ST_SNAP_FIN:   state_in = tdvq_pkg::ST_EMIT;
         tdvq_pkg::ST_TAP:        state_in = tdvq_pkg::ST_EMIT;
         tdvq_pkg::ST_EMIT: begin
            if (!status.out_full) state_in = tdvq_pkg::ST_IDLE;
         end
         default: state_in = tdvq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      op        = tdvq_pkg::OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         tdvq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) op = tdvq_pkg::OP_LOAD;
         end
         tdvq_pkg::ST_HIT_DX:    op = tdvq_pkg::OP_HIT_DX;
         tdvq_pkg::ST_HIT_DY:    op = tdvq_pkg::OP_HIT_DY;
         tdvq_pkg::ST_HIT_RR:    op = tdvq_pkg::OP_HIT_RR;
         tdvq_pkg::ST_HIT_FIN:   op = tdvq_pkg::OP_HIT_FIN;
         tdvq_pkg::ST_DRAG_MUL:  op = tdvq_pkg::OP_DRAG_MUL;
         tdvq_pkg::ST_DRAG_DIV:  op = tdvq_pkg::OP_DRAG_DIV;
         tdvq_pkg::ST_DRAG_SUM:  op = tdvq_pkg::OP_DRAG_SUM;
         tdvq_pkg::ST_SNAP_CHK: begin
            if (!status.snap_on) op = tdvq_pkg::OP_COMMIT_PLAIN;
         end
         tdvq_pkg::ST_SNAP_MUL1: op = tdvq_pkg::OP_SNAP_MUL1;
         tdvq_pkg::ST_SNAP_DIV1: op = tdvq_pkg::OP_SNAP_DIV1;
         tdvq_pkg::ST_SNAP_IDX:  op = tdvq_pkg::OP_SNAP_IDX;
         tdvq_pkg::ST_SNAP_MUL2: op = tdvq_pkg::OP_SNAP_MUL2;
         tdvq_pkg::ST_SNAP_DIV2: op = tdvq_pkg::OP_SNAP_DIV2;
         tdvq_pkg::ST_SNAP_FIN:  op = tdvq_pkg::OP_SNAP_FIN;
         tdvq_pkg::ST_TAP:       op = tdvq_pkg::OP_TAP;
         tdvq_pkg::ST_EMIT: begin
            if (!status.out_full) op = tdvq_pkg::OP_EMIT;
         end
         default: ;
      endcase
   end

endmodule

@@ src/touch_drag_value_quantizer_unit.sv @@
// Each division runs on a shared 2-bit-per-cycle divider; a drag uses one
// or three. One item at a time: the next transfer can be taken in the cycle after
// the result is registered. Synchronous active-high reset restores register defaults,
// clears dial state and tap flag, and empties the output register.
module touch_drag_value_quantizer_unit (
   input logic        clock,
   input logic        reset,
   tdvq_req_if.sink   req_chan,
   tdvq_rsp_if.source rsp_chan,
   tdvq_csr_if.sink   csr_chan
);

   tdvq_pkg::tdvq_op_type     op;
   tdvq_pkg::tdvq_status_type status;
   logic                      req_ready;

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   tdvq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .status    (status),
      .op        (op),
      .req_ready (req_ready)
   );

   tdvq_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .op             (op),
      .status         (status),
      .req_func       (req_chan.func),
      .req_touch_x    (req_chan.touch_x),
      .req_touch_y    (req_chan.touch_y),
      .csr_valid      (csr_chan.valid),
      .csr_reg_index  (csr_chan.reg_index),
      .csr_wr_data    (csr_chan.wr_data),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_hit        (rsp_chan.hit),
      .rsp_dial_value (rsp_chan.dial_value),
      .rsp_tapped     (rsp_chan.tapped)
   );

endmodule

@@ verif/tb_touch_drag_value_quantizer_unit.sv @@
module tb_touch_drag_value_quantizer_unit;
   import tdvq_pkg::*;

   typedef struct {
      logic                         hit;
      logic signed [ValueWidth-1:0] value;
      logic                         tapped;
   } dial_outcome_t;

   logic clock;
   logic reset;

   tdvq_req_if req_bus ();
   tdvq_rsp_if rsp_bus ();
   tdvq_csr_if csr_bus ();

   logic [CoordWidth-1:0]        cfg_center_x;
   logic [CoordWidth-1:0]        cfg_center_y;
   logic [CoordWidth-1:0]        cfg_radius;
   logic signed [ValueWidth-1:0] cfg_min;
   logic signed [ValueWidth-1:0] cfg_max;
   logic [StepWidth-1:0]         cfg_steps;
   logic signed [ValueWidth-1:0] cfg_start;

   logic signed [ValueWidth-1:0] dial_value;
   logic signed [ValueWidth-1:0] grab_value;
   logic [CoordWidth-1:0]        grab_y;
   logic                         tap_latched;

   dial_outcome_t pending_dial_results[$];
   dial_outcome_t expected_head;

   int error_count;
   int items_sent;
   int rsp_hold_cycles;
   bit req_gaps_on;
   bit rsp_stalls_on;

   touch_drag_value_quantizer_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void reset_dial_model();
      cfg_center_x = '0;
      cfg_center_y = '0;
      cfg_radius   = RADIUS_RESET;
      cfg_min      = '0;
      cfg_max      = MAX_RESET;
      cfg_steps    = STEPS_RESET;
      cfg_start    = '0;
      dial_value   = '0;
      grab_value   = '0;
      grab_y       = '0;
      tap_latched  = 1'b0;
   endfunction

   function automatic void apply_register(input logic [CsrIndexWidth-1:0] index,
                                          input logic [CsrDataWidth-1:0] data);
      case (index)
         CSR_CENTER_X:    cfg_center_x = data[CoordWidth-1:0];
         CSR_CENTER_Y:    cfg_center_y = data[CoordWidth-1:0];
         CSR_DIAL_RADIUS: cfg_radius   = data[CoordWidth-1:0];
         CSR_MIN_VALUE:   cfg_min      = data[ValueWidth-1:0];
         CSR_MAX_VALUE:   cfg_max      = data[ValueWidth-1:0];
         CSR_STEP_COUNT:  cfg_steps    = data[StepWidth-1:0];
         CSR_START_VALUE: begin
            cfg_start  = data[ValueWidth-1:0];
            dial_value = data[ValueWidth-1:0];
         end
         default: ;
      endcase
   endfunction

   function automatic longint floor_quot(input longint a, input longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q = q - 1;
      return q;
   endfunction

   // nearest integer, ties toward plus infinity
   function automatic longint nearest_quot(input longint a, input longint b);
      return floor_quot(2 * a + b, 2 * b);
   endfunction

   function automatic longint snap_to_level(input longint v);
      longint span;
      longint levels;
      longint idx;
      span = longint'(cfg_max) - longint'(cfg_min);
      if (cfg_steps <= 1) return v;
      if (span <= 0) return longint'(cfg_min);
      levels = longint'(cfg_steps) - 1;
      idx = nearest_quot((v - longint'(cfg_min)) * levels, span);
      if (idx < 0) idx = 0;
      if (idx > levels) idx = levels;
      return longint'(cfg_min) + nearest_quot(idx * span, levels);
   endfunction

   function automatic dial_outcome_t dial_after_event(input tdvq_func_type f,
                                                      input logic [CoordWidth-1:0] x,
                                                      input logic [CoordWidth-1:0] y);
      dial_outcome_t res;
      longint dx;
      longint dy;
      longint r;
      longint span;
      longint travel;
      longint shift;
      longint v;
      res.hit = 1'b0;
      case (f)
         FUNC_BEGIN: begin
            dx = longint'(x) - longint'(cfg_center_x);
            dy = longint'(y) - longint'(cfg_center_y);
            r  = longint'(cfg_radius);
            if (dx * dx + dy * dy <= r * r) begin
               grab_value = dial_value;
               grab_y     = y;
               res.hit    = 1'b1;
            end
         end
         FUNC_MOVE: begin
            span   = longint'(cfg_max) - longint'(cfg_min);
            travel = longint'(y) - longint'(grab_y);
            r      = (cfg_radius == 0) ? 1 : longint'(cfg_radius);
            shift  = 0;
            if (span > 0) shift = nearest_quot(-travel * span, 2 * r);
            v = longint'(grab_value) + shift;
            if (v < longint'(cfg_min)) v = longint'(cfg_min);
            else if (v > longint'(cfg_max)) v = longint'(cfg_max);
            dial_value = ValueWidth'(snap_to_level(v));
         end
         FUNC_TAP: tap_latched = 1'b1;
         default: ;
      endcase
      res.value  = dial_value;
      res.tapped = tap_latched;
      return res;
   endfunction

   function automatic logic [CoordWidth-1:0] coord_near(input logic [CoordWidth-1:0] c,
                                                        input int reach);
      int p;
      p = int'($urandom_range(0, 2 * reach)) - reach + int'(c);
      if (p < 0) p = 0;
      if (p > 1023) p = 1023;
      return CoordWidth'(p);
   endfunction

   task automatic send_event(input tdvq_func_type f, input logic [CoordWidth-1:0] x,
                             input logic [CoordWidth-1:0] y);
      int gap;
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.func    <= f;
      req_bus.touch_x <= x;
      req_bus.touch_y <= y;
      do @(posedge clock); while (!req_bus.ready);
      pending_dial_results.push_back(dial_after_event(f, x, y));
      items_sent++;
   endtask

   task automatic send_noise();
      send_event(tdvq_func_type'($urandom_range(0, 3)), CoordWidth'($urandom_range(0, 1023)),
                 CoordWidth'($urandom_range(0, 1023)));
   endtask

   // hold requests until every pending result has transferred
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_dial_results.size() != 0);
   endtask

   task automatic write_register(input logic [CsrIndexWidth-1:0] index,
                                 input logic [CsrDataWidth-1:0] data);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= index;
      csr_bus.wr_data   <= data;
      do @(posedge clock); while (!csr_bus.ready);
      apply_register(index, data);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [CoordWidth-1:0] cx, input logic [CoordWidth-1:0] cy,
                                input logic [CoordWidth-1:0] r, input logic [ValueWidth-1:0] lo,
                                input logic [ValueWidth-1:0] hi,
                                input logic [StepWidth-1:0] steps,
                                input logic [ValueWidth-1:0] start);
      write_register(CSR_CENTER_X, CsrDataWidth'(cx));
      write_register(CSR_CENTER_Y, CsrDataWidth'(cy));
      write_register(CSR_DIAL_RADIUS, CsrDataWidth'(r));
      write_register(CSR_MIN_VALUE, CsrDataWidth'(lo));
      write_register(CSR_MAX_VALUE, CsrDataWidth'(hi));
      write_register(CSR_STEP_COUNT, CsrDataWidth'(steps));
      write_register(CSR_START_VALUE, CsrDataWidth'(start));
   endtask

   task automatic randomize_settings();
      logic [CoordWidth-1:0]        r;
      logic signed [ValueWidth-1:0] lo;
      logic signed [ValueWidth-1:0] hi;
      logic signed [ValueWidth-1:0] start;
      logic [StepWidth-1:0]         steps;
      case ($urandom_range(0, 4))
         0: r = 10'd1;
         1: r = CoordWidth'($urandom_range(2, 16));
         2: r = CoordWidth'($urandom_range(17, 128));
         3: r = CoordWidth'($urandom_range(129, 1022));
         default: r = 10'd1023;
      endcase
      lo = ValueWidth'($urandom_range(0, 24'hFFFFFF));
      case ($urandom_range(0, 5))
         0: hi = ValueWidth'($urandom_range(0, 24'hFFFFFF));
         1: begin
            lo = 24'sh800000;
            hi = 24'sh7FFFFF;
         end
         2: begin
            lo = ValueWidth'(int'($urandom_range(0, 4096)) - 2048);
            hi = lo + ValueWidth'($urandom_range(1, 65536));
         end
         3: hi = lo - ValueWidth'($urandom_range(0, 255));
         default: begin
            lo = ValueWidth'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            hi = lo + ValueWidth'($urandom_range(256, 1 << 21));
         end
      endcase
      case ($urandom_range(0, 4))
         0, 1: steps = 11'd1;
         2: steps = StepWidth'($urandom_range(2, 16));
         3: steps = StepWidth'($urandom_range(17, 1024));
         default: steps = 11'd1024;
      endcase
      start = ($urandom_range(0, 2) == 0) ? ValueWidth'($urandom_range(0, 24'hFFFFFF)) : lo;
      load_settings(CoordWidth'($urandom_range(0, 1023)), CoordWidth'($urandom_range(0, 1023)),
                    r, lo, hi, steps, start);
   endtask

   task automatic play_gesture();
      int                    moves;
      int                    reach;
      logic [CoordWidth-1:0] x;
      logic [CoordWidth-1:0] y;
      logic [CoordWidth-1:0] anchor;
      reach = (int'(cfg_radius) * 7) / 10;
      if ($urandom_range(0, 9) < 8) begin
         x = coord_near(cfg_center_x, reach);
         y = coord_near(cfg_center_y, reach);
      end else begin
         x = CoordWidth'($urandom_range(0, 1023));
         y = CoordWidth'($urandom_range(0, 1023));
      end
      send_event(FUNC_BEGIN, x, y);
      anchor = y;
      moves = $urandom_range(1, 6);
      repeat (moves) begin
         if ($urandom_range(0, 6) == 0) y = CoordWidth'($urandom_range(0, 1023));
         else y = coord_near(anchor, 2 * int'(cfg_radius) + 2);
         send_event(FUNC_MOVE, CoordWidth'($urandom_range(0, 1023)), y);
      end
      if ($urandom_range(0, 7) == 0) send_event(FUNC_TAP, x, y);
      if ($urandom_range(0, 4) != 0) send_event(FUNC_END, x, y);
   endtask

   task automatic run_random_items(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(0, 6) == 0) send_noise();
         else play_gesture();
      end
   endtask

   task automatic test_reset_defaults();
      send_event(FUNC_END, 10'd0, 10'd0);
      send_event(FUNC_MOVE, 10'd1023, 10'd1023);
      send_event(FUNC_BEGIN, 10'd1023, 10'd1023);
      send_event(FUNC_BEGIN, 10'd0, 10'd32);
      send_event(FUNC_MOVE, 10'd0, 10'd0);
      send_event(FUNC_MOVE, 10'd0, 10'd1023);
      send_event(FUNC_TAP, 10'd1023, 10'd0);
      send_event(FUNC_END, 10'd0, 10'd0);
   endtask

   task automatic test_zero_radius_full_range();
      wait_for_results();
      load_settings(10'd512, 10'd512, 10'd0, 24'sh800000, 24'sh7FFFFF, 11'd1024, 24'sh7FFFFF);
      send_event(FUNC_BEGIN, 10'd513, 10'd512);
      send_event(FUNC_BEGIN, 10'd512, 10'd512);
      send_event(FUNC_MOVE, 10'd512, 10'd511);
      send_event(FUNC_MOVE, 10'd512, 10'd1023);
      send_event(FUNC_MOVE, 10'd512, 10'd512);
      send_event(FUNC_END, 10'd512, 10'd512);
   endtask

   task automatic test_inverted_bounds();
      wait_for_results();
      load_settings(10'd0, 10'd1023, 10'd1023, 24'sd1000, -24'sd1000, 11'd1, 24'sd5);
      send_event(FUNC_BEGIN, 10'd0, 10'd1023);
      send_event(FUNC_MOVE, 10'd0, 10'd0);
      wait_for_results();
      write_register(CSR_STEP_COUNT, 24'd5);
      send_event(FUNC_MOVE, 10'd0, 10'd500);
      wait_for_results();
      write_register(CSR_MAX_VALUE, 24'd1000);
      send_event(FUNC_MOVE, 10'd0, 10'd700);
      send_event(FUNC_TAP, 10'd0, 10'd0);
   endtask

   task automatic test_output_backpressure();
      wait_for_results();
      load_settings(10'd512, 10'd512, 10'd200, 24'sd0, 24'sd25600, 11'd11, 24'sd12800);
      req_gaps_on = 1'b0;
      rsp_hold_cycles = 300;
      send_event(FUNC_BEGIN, 10'd500, 10'd520);
      repeat (6) send_event(FUNC_MOVE, 10'd500, coord_near(10'd520, 300));
      send_event(FUNC_END, 10'd500, 10'd520);
      wait_for_results();
      req_gaps_on = 1'b1;
   endtask

   task automatic test_random_gestures();
      repeat (9) begin
         wait_for_results();
         randomize_settings();
         req_gaps_on   = ($urandom_range(0, 3) != 0);
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         run_random_items(40);
      end
   endtask

   task automatic test_back_to_back();
      wait_for_results();
      randomize_settings();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      run_random_items(60);
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            stall_left = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (rsp_stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_dial_results.size() == 0) begin
            $display("%0t: unexpected result transfer, dial_value %0d", $time,
                     rsp_bus.dial_value);
            error_count++;
         end else begin
            expected_head = pending_dial_results.pop_front();
            if (rsp_bus.hit !== expected_head.hit) begin
               $display("%0t: hit expected %0b actual %0b", $time, expected_head.hit,
                        rsp_bus.hit);
               error_count++;
            end
            if (rsp_bus.dial_value !== expected_head.value) begin
               $display("%0t: dial_value expected %0d actual %0d", $time,
                        expected_head.value, rsp_bus.dial_value);
               error_count++;
            end
            if (rsp_bus.tapped !== expected_head.tapped) begin
               $display("%0t: tapped expected %0b actual %0b", $time,
                        expected_head.tapped, rsp_bus.tapped);
               error_count++;
            end
         end
      end
   end

   initial begin
      #5000000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      error_count     = 0;
      items_sent      = 0;
      rsp_hold_cycles = 0;
      req_gaps_on     = 1'b1;
      rsp_stalls_on   = 1'b1;
      reset_dial_model();
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.func      <= FUNC_END;
      req_bus.touch_x   <= '0;
      req_bus.touch_y   <= '0;
      csr_bus.valid     <= 1'b0;
      csr_bus.reg_index <= CSR_CENTER_X;
      csr_bus.wr_data   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_zero_radius_full_range();
      test_inverted_bounds();
      test_output_backpressure();
      test_random_gestures();
      test_back_to_back();
      wait_for_results();
      repeat (10) @(posedge clock);
      if (pending_dial_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_dial_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
